FILE: design/apf_pkg.sv
package apf_pkg;

    // Graph size limit and fixed field widths
    localparam int APF_MAX_VERTICES = 64;
    localparam int APF_VID_W        = 6;
    localparam int APF_CNT_W        = 7;
    localparam int APF_MASK_W       = 64;

    // Stream widths, padded to whole bytes
    localparam int APF_S_DATA_W = 16;
    localparam int APF_M_DATA_W = 72;

    // Configuration port
    localparam int APF_APB_AW  = 3;
    localparam int APF_APB_DW  = 32;
    localparam logic REG_VERTEX_COUNT = 1'b0;
    localparam logic [APF_CNT_W-1:0] APF_VCOUNT_RESET = 7'd64;

    // Input item kinds carried on tuser
    localparam logic MODE_EDGE  = 1'b0;
    localparam logic MODE_SOLVE = 1'b1;

endpackage

FILE: design/articulation_point_finder.sv
// Cut vertex finder for an undirected graph of up to MAX_VERTICES vertices.
// Input stream: each transfer carries tuser[0] = mode and tdata = the two endpoints.
// Mode edge sets the edge in an adjacency bit matrix held in RAM (read-modify-write of
// both rows); the block is busy through its read and two write states and emits nothing.
// Endpoints at or above the vertex count, and self-loops, are dropped.
// Mode solve runs a depth-first search from vertex 0 under a small sequencer. One
// shared bit-scan step tests one adjacency bit per cycle, apart from back-edge, descent
// and return steps; the current vertex lives in registers, its ancestors in a frame RAM.
// Each already-visited neighbor other than the tree parent costs a back-edge step; the
// solve ends with one result transfer (cut mask and count) on the output stream.
// The input is not ready while an item is in work.
// The result sits in an output register, so the next items are taken while it waits;
// a following solve holds at its end until that register is free.
// After each solve the graph and all traversal state are cleared through valid bits.
// Reset (synchronous, active low) clears the graph, empties the output and sets
// vertex_count to 64. vertex_count is at APB byte address 0; write it only while idle.
module articulation_point_finder import apf_pkg::*; #(
    parameter int MAX_VERTICES = APF_MAX_VERTICES
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // Input stream
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [APF_S_DATA_W-1:0] s_axis_tdata,   // [5:0] from_vertex, [11:6] to_vertex
    input  logic [0:0]              s_axis_tuser,   // [0] mode
    // Result stream
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [APF_M_DATA_W-1:0] m_axis_tdata,   // [63:0] cut_mask, [70:64] cut_count
    // Configuration port
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [APF_APB_AW-1:0]   paddr,
    input  logic [APF_APB_DW-1:0]   pwdata,
    output logic [APF_APB_DW-1:0]   prdata,
    output logic                    pready
);

    localparam int VW = $clog2(MAX_VERTICES);
    localparam int PW = VW + 1;
    localparam logic [PW-1:0] PAR_NONE = {1'b1, {VW{1'b0}}};
    localparam logic [MAX_VERTICES-1:0] ROW_ONE = MAX_VERTICES'(1);
    localparam logic [APF_CNT_W-1:0] MAX_COUNT = APF_CNT_W'(MAX_VERTICES);

    typedef struct packed {
        logic [VW-1:0] vtx;
        logic [PW-1:0] par;
        logic [VW-1:0] disc;
        logic [VW-1:0] low;
    } t_frame;

    typedef enum logic [3:0] {
        S_IDLE, S_EDGE_RD, S_EDGE_WA, S_EDGE_WB, S_LOAD, S_LATCH,
        S_SCAN, S_BACK, S_POP, S_RESUME, S_OUT
    } t_state;

    t_state                  r_state;
    logic [APF_CNT_W-1:0]    r_vcount;
    logic [VW-1:0]           r_a;
    logic [VW-1:0]           r_b;
    logic [MAX_VERTICES-1:0] r_row_ok;
    logic                    r_rd_ok;
    logic [MAX_VERTICES-1:0] r_row;
    logic [MAX_VERTICES-1:0] r_visited;
    logic [MAX_VERTICES-1:0] r_cut;
    logic [VW:0]             r_cnt;
    logic [VW-1:0]           r_u;
    logic [PW-1:0]           r_u_par;
    logic [VW-1:0]           r_u_disc;
    logic [VW-1:0]           r_u_low;
    logic [VW:0]             r_pos;
    logic [VW:0]             r_sp;
    logic [VW-1:0]           r_time;
    logic [1:0]              r_rc;
    logic                    r_out_valid;
    logic [APF_MASK_W-1:0]   r_out_mask;
    logic [APF_CNT_W-1:0]    r_out_cnt;

    logic [APF_CNT_W-1:0]    eff_vcount;
    logic [APF_VID_W-1:0]    in_from;
    logic [APF_VID_W-1:0]    in_to;
    logic                    in_acc;
    logic                    edge_ok;
    logic                    start_solve;
    logic [VW-1:0]           scan_v;
    logic                    scan_end;
    logic                    scan_hit;
    logic                    do_push;
    logic [VW:0]             sp_m1;
    logic [VW:0]             sp_m2;
    logic [MAX_VERTICES-1:0] adj_row;
    logic [VW-1:0]           adj_raddr;
    logic                    adj_we;
    logic [VW-1:0]           adj_waddr;
    logic [MAX_VERTICES-1:0] adj_wdata;
    logic [MAX_VERTICES-1:0] adj_rdata;
    logic                    disc_we;
    logic [VW-1:0]           disc_waddr;
    logic [VW-1:0]           disc_rdata;
    logic                    frame_we;
    t_frame                  frame_wdata;
    t_frame                  frame_rd;
    logic                    cfg_wr;
    logic                    out_free;
    logic                    out_load;

    // Decode inputs and the effective vertex count
    assign in_from    = s_axis_tdata[APF_VID_W-1:0];
    assign in_to      = s_axis_tdata[2*APF_VID_W-1:APF_VID_W];
    assign eff_vcount = (r_vcount > MAX_COUNT) ? MAX_COUNT : r_vcount;
    assign in_acc     = s_axis_tvalid && s_axis_tready;
    assign edge_ok    = ({1'b0, in_from} < eff_vcount) && ({1'b0, in_to} < eff_vcount)
                        && (in_from != in_to);
    assign start_solve = in_acc && (s_axis_tuser[0] == MODE_SOLVE) && (eff_vcount != '0);

    // Shared scan step over the current row
    assign scan_v   = r_pos[VW-1:0];
    assign scan_end = (APF_CNT_W'(r_pos) >= eff_vcount);
    assign scan_hit = r_row[scan_v];
    assign do_push  = (r_state == S_SCAN) && !scan_end && scan_hit && !r_visited[scan_v];
    assign sp_m1    = r_sp - (VW+1)'(1);
    assign sp_m2    = r_sp - (VW+1)'(2);
    assign adj_row  = r_rd_ok ? adj_rdata : '0;
    assign out_free = !r_out_valid || m_axis_tready;
    assign out_load = (r_state == S_OUT) && out_free;

    // Memory port steering
    always_comb begin
        case (r_state)
            S_EDGE_RD: adj_raddr = r_a;
            S_EDGE_WA: adj_raddr = r_b;
            default:   adj_raddr = r_u;
        endcase
        adj_we    = (r_state == S_EDGE_WA) || (r_state == S_EDGE_WB);
        adj_waddr = (r_state == S_EDGE_WA) ? r_a : r_b;
        adj_wdata = (r_state == S_EDGE_WA) ? (adj_row | (ROW_ONE << r_b))
                                           : (adj_row | (ROW_ONE << r_a));
        disc_we    = start_solve || do_push;
        disc_waddr = (r_state == S_IDLE) ? '0 : scan_v;
        frame_we   = do_push;
        frame_wdata.vtx  = r_u;
        frame_wdata.par  = r_u_par;
        frame_wdata.disc = r_u_disc;
        frame_wdata.low  = r_u_low;
    end

    apf_ram #(.WIDTH(MAX_VERTICES), .DEPTH(MAX_VERTICES)) u_adj_ram (
        .i_clk   (i_clk),
        .i_we    (adj_we),
        .i_waddr (adj_waddr),
        .i_wdata (adj_wdata),
        .i_raddr (adj_raddr),
        .o_rdata (adj_rdata)
    );

    apf_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_disc_ram (
        .i_clk   (i_clk),
        .i_we    (disc_we),
        .i_waddr (disc_waddr),
        .i_wdata (r_time),
        .i_raddr (scan_v),
        .o_rdata (disc_rdata)
    );

    apf_ram #(.WIDTH($bits(t_frame)), .DEPTH(MAX_VERTICES)) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (frame_we),
        .i_waddr (sp_m1[VW-1:0]),
        .i_wdata (frame_wdata),
        .i_raddr (sp_m2[VW-1:0]),
        .o_rdata (frame_rd)
    );

    // Configuration register
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_VERTEX_COUNT) ? APF_APB_DW'(r_vcount) : '0;

    // Sequencer, traversal state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_vcount    <= APF_VCOUNT_RESET;
            r_row_ok    <= '0;
            r_visited   <= '0;
            r_cut       <= '0;
            r_cnt       <= '0;
            r_sp        <= '0;
            r_time      <= '0;
            r_rc        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_ok <= r_row_ok[adj_raddr];
            if (cfg_wr && paddr[2] == REG_VERTEX_COUNT) begin
                r_vcount <= pwdata[APF_CNT_W-1:0];
            end
            // Hold the result until the receiver takes it
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_a <= in_from[VW-1:0];
                        r_b <= in_to[VW-1:0];
                        if (s_axis_tuser[0] == MODE_SOLVE) begin
                            if (start_solve) begin
                                // Enter the root
                                r_u       <= '0;
                                r_u_par   <= PAR_NONE;
                                r_u_disc  <= r_time;
                                r_u_low   <= r_time;
                                r_pos     <= '0;
                                r_visited <= ROW_ONE;
                                r_time    <= r_time + 1'b1;
                                r_sp      <= r_sp + 1'b1;
                                r_state   <= S_LOAD;
                            end else begin
                                r_state <= S_OUT;
                            end
                        end else if (edge_ok) begin
                            r_state <= S_EDGE_RD;
                        end
                    end
                end
                S_EDGE_RD: begin
                    r_state <= S_EDGE_WA;
                end
                S_EDGE_WA: begin
                    r_row_ok[r_a] <= 1'b1;
                    r_state       <= S_EDGE_WB;
                end
                S_EDGE_WB: begin
                    r_row_ok[r_b] <= 1'b1;
                    r_state       <= S_IDLE;
                end
                S_LOAD: begin
                    r_state <= S_LATCH;
                end
                S_LATCH: begin
                    r_row   <= adj_row;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (scan_end) begin
                        r_state <= S_POP;
                    end else if (do_push) begin
                        // Save the current frame and descend into the new vertex
                        if (r_u == '0 && r_rc != 2'd2) begin
                            r_rc <= r_rc + 1'b1;
                        end
                        r_u               <= scan_v;
                        r_u_par           <= {1'b0, r_u};
                        r_u_disc          <= r_time;
                        r_u_low           <= r_time;
                        r_pos             <= '0;
                        r_visited[scan_v] <= 1'b1;
                        r_time            <= r_time + 1'b1;
                        r_sp              <= r_sp + 1'b1;
                        r_state           <= S_LOAD;
                    end else begin
                        r_pos <= r_pos + 1'b1;
                        if (scan_hit && {1'b0, scan_v} != r_u_par) begin
                            r_state <= S_BACK;
                        end
                    end
                end
                S_BACK: begin
                    // Back edge: pull the low time down to the ancestor's discovery time
                    if (disc_rdata < r_u_low) begin
                        r_u_low <= disc_rdata;
                    end
                    r_state <= S_SCAN;
                end
                S_POP: begin
                    r_sp <= sp_m1;
                    if (r_u_par == PAR_NONE) begin
                        if (r_rc == 2'd2) begin
                            r_cut[0] <= 1'b1;
                            r_cnt    <= r_cnt + 1'b1;
                        end
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_RESUME;
                    end
                end
                S_RESUME: begin
                    // Fold the child's low time into the parent and test the parent
                    r_u      <= frame_rd.vtx;
                    r_u_par  <= frame_rd.par;
                    r_u_disc <= frame_rd.disc;
                    r_u_low  <= (r_u_low < frame_rd.low) ? r_u_low : frame_rd.low;
                    r_pos    <= {1'b0, r_u} + (VW+1)'(1);
                    if (frame_rd.vtx != '0 && r_u_low >= frame_rd.disc
                        && !r_cut[frame_rd.vtx]) begin
                        r_cut[frame_rd.vtx] <= 1'b1;
                        r_cnt               <= r_cnt + 1'b1;
                    end
                    r_state <= S_LOAD;
                end
                S_OUT: begin
                    // Hand over the result and clear the graph
                    if (out_free) begin
                        r_out_mask  <= APF_MASK_W'(r_cut);
                        r_out_cnt   <= APF_CNT_W'(r_cnt);
                        r_row_ok    <= '0;
                        r_visited   <= '0;
                        r_cut       <= '0;
                        r_cnt       <= '0;
                        r_sp        <= '0;
                        r_time      <= '0;
                        r_rc        <= '0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_cnt, r_out_mask};

    // The stack never holds more frames than there are vertices
    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= (VW+1)'(MAX_VERTICES))
        else $error("dfs stack overflow");

    // A resumed frame is the parent recorded for the popped vertex
    a_frame_parent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_RESUME |-> (!r_u_par[VW] && frame_rd.vtx == r_u_par[VW-1:0]))
        else $error("frame does not match tree parent");

    // Only visited vertices are marked
    a_cut_visited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cut & ~r_visited) == '0)
        else $error("cut mark on unvisited vertex");

    // Running count tracks the mask
    a_cut_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == $countones(r_cut))
        else $error("cut count out of step with mask");

endmodule

FILE: design/apf_ram.sv
module apf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
